>>> sv/assert_macros.svh
// Assertion macros for the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, off while reset is low.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  `ASSERT_AT(lbl, clk, rst_n, !(expr), msg)

`endif

>>> sv/pbwt_pkg.sv
// Shared constants, codes and controller/datapath interface types of the
// prefix and divergence sort unit. Depends on nothing.
package pbwt_pkg;

  localparam int MAX_HAPS  = 64;
  localparam int SITE_BITS = 20;
  localparam int HAP_W     = $clog2(MAX_HAPS);
  localparam int CNT_W     = $clog2(MAX_HAPS + 1);
  localparam int IDX_W     = 6;
  localparam int OUT_W     = 20;
  localparam int CFG_W     = 7;
  localparam logic [CFG_W-1:0] HAP_COUNT_RST = CFG_W'(64);

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_READ    = 2'd1,
    KIND_RESTART = 2'd2
  } kind_e;

  localparam logic RES_PASS = 1'b0;
  localparam logic RES_READ = 1'b1;

  typedef struct packed {
    logic load_we;
    logic restart;
    logic rd_item;
    logic pass_start;
    logic scan_en;
    logic copy_en;
    logic out_read;
    logic out_pass;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic copy_done;
  } sts_t;

endpackage

>>> sv/pbwt_ctrl.sv
// Controller of the prefix and divergence sort unit: item decode, pass
// sequencing and result handshake. Depends on pbwt_pkg.
module pbwt_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                kind_i,
  input  logic                      site_last_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output pbwt_pkg::cmd_t            cmd_o,
  input  pbwt_pkg::sts_t            sts_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_COPY
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_stall_o  = !((state_q == S_IDLE) && (!out_valid_q || !out_stall_i));
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (pbwt_pkg::kind_e'(kind_i))
            pbwt_pkg::KIND_LOAD: begin
              cmd_o.load_we = 1'b1;
              if (site_last_i) begin
                cmd_o.pass_start = 1'b1;
                state_d          = S_SCAN;
              end
            end
            pbwt_pkg::KIND_READ: begin
              cmd_o.rd_item = 1'b1;
              state_d       = S_READ;
            end
            pbwt_pkg::KIND_RESTART: begin
              cmd_o.restart = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_READ: begin
        cmd_o.out_read = 1'b1;
        state_d        = S_IDLE;
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_COPY;
        end
      end
      S_COPY: begin
        cmd_o.copy_en = 1'b1;
        if (sts_i.copy_done) begin
          cmd_o.out_pass = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_read || cmd_o.out_pass) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

>>> sv/pbwt_dpath.sv
// Datapath of the prefix and divergence sort unit: prefix and divergence
// memories, allele column, ones buffers, scan pipeline and result register.
// Depends on pbwt_pkg.
module pbwt_dpath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pbwt_pkg::cmd_t              cmd_i,
  output pbwt_pkg::sts_t              sts_o,
  input  logic                        cfg_we_i,
  input  logic [pbwt_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic [pbwt_pkg::IDX_W-1:0]  hap_index_i,
  input  logic                        allele_i,
  output logic                        result_kind_o,
  output logic [pbwt_pkg::OUT_W-1:0]  site_number_o,
  output logic [pbwt_pkg::IDX_W-1:0]  hap_id_o,
  output logic [pbwt_pkg::OUT_W-1:0]  divergence_o
);

  localparam int MAX_HAPS = pbwt_pkg::MAX_HAPS;
  localparam int HAP_W    = pbwt_pkg::HAP_W;
  localparam int CNT_W    = pbwt_pkg::CNT_W;
  localparam int SB       = pbwt_pkg::SITE_BITS;
  localparam int OUT_W    = pbwt_pkg::OUT_W;
  localparam int IDX_W    = pbwt_pkg::IDX_W;
  localparam int CFG_W    = pbwt_pkg::CFG_W;
  localparam logic [SB-1:0] SITE_MAX = {SB{1'b1}};

  logic [CFG_W-1:0] hap_count_q;
  logic [CNT_W-1:0] n_act;
  logic             idx_ok;

  logic [HAP_W-1:0] prefix_mem [MAX_HAPS];
  logic [SB-1:0]    div_mem    [MAX_HAPS];
  logic             col_mem    [MAX_HAPS];
  logic [HAP_W-1:0] ones_hap_mem [MAX_HAPS];
  logic [SB-1:0]    ones_div_mem [MAX_HAPS];
  logic [MAX_HAPS-1:0] ent_valid_q;

  logic [HAP_W-1:0] rd_addr, rd_addr_q, pre_rd_q, h_eff, h2_q;
  logic [SB-1:0]    div_rd_q, d_eff, d2_q, pm, qm, p_q, q_q, start;
  logic             rd_vld_q, rd_ok_q, col_rd_q;
  logic [HAP_W-1:0] oh_rd_q, cp_wa_q;
  logic [SB-1:0]    od_rd_q;
  logic [CNT_W-1:0] issue_cnt_q, zeros_q, ones_q, cp_cnt_q;
  logic             s1_q, s2_q, cp_v_q;
  logic             issue, cp_issue, zero_wr, one_wr;
  logic             pw_en;
  logic [HAP_W-1:0] pw_addr, pw_hap;
  logic [SB-1:0]    pw_div;
  logic [SB-1:0]    site_cnt_q;

  always_comb begin
    if (32'(hap_count_q) > MAX_HAPS) begin
      n_act = CNT_W'(MAX_HAPS);
    end else begin
      n_act = CNT_W'(hap_count_q);
    end
  end

  assign idx_ok   = 32'(hap_index_i) < 32'(n_act);
  assign issue    = cmd_i.scan_en && (issue_cnt_q < n_act);
  assign cp_issue = cmd_i.copy_en && (cp_cnt_q < ones_q);
  assign rd_addr  = cmd_i.scan_en ? HAP_W'(issue_cnt_q) : HAP_W'(hap_index_i);

  assign h_eff = rd_vld_q ? pre_rd_q : rd_addr_q;
  assign d_eff = rd_vld_q ? div_rd_q : '0;

  assign pm      = (d2_q > p_q) ? d2_q : p_q;
  assign qm      = (d2_q > q_q) ? d2_q : q_q;
  assign zero_wr = s2_q && !col_rd_q;
  assign one_wr  = s2_q && col_rd_q;
  assign start   = (site_cnt_q == SITE_MAX) ? site_cnt_q : site_cnt_q + SB'(1);

  assign pw_en   = zero_wr || cp_v_q;
  assign pw_addr = cp_v_q ? cp_wa_q : HAP_W'(zeros_q);
  assign pw_hap  = cp_v_q ? oh_rd_q : h2_q;
  assign pw_div  = cp_v_q ? od_rd_q : pm;

  assign sts_o.scan_done = (issue_cnt_q == n_act) && !s1_q && !s2_q;
  assign sts_o.copy_done = (cp_cnt_q == ones_q) && !cp_v_q;

  always_ff @(posedge clk_i) begin
    pre_rd_q  <= prefix_mem[rd_addr];
    div_rd_q  <= div_mem[rd_addr];
    rd_vld_q  <= ent_valid_q[rd_addr];
    rd_addr_q <= rd_addr;
    if (pw_en) begin
      prefix_mem[pw_addr] <= pw_hap;
      div_mem[pw_addr]    <= pw_div;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we && idx_ok) begin
      col_mem[HAP_W'(hap_index_i)] <= allele_i;
    end
    col_rd_q <= col_mem[h_eff];
    h2_q     <= h_eff;
    d2_q     <= d_eff;
  end

  always_ff @(posedge clk_i) begin
    if (one_wr) begin
      ones_hap_mem[HAP_W'(ones_q)] <= h2_q;
      ones_div_mem[HAP_W'(ones_q)] <= qm;
    end
    oh_rd_q <= ones_hap_mem[HAP_W'(cp_cnt_q)];
    od_rd_q <= ones_div_mem[HAP_W'(cp_cnt_q)];
    cp_wa_q <= HAP_W'(zeros_q + cp_cnt_q);
    if (cmd_i.rd_item) begin
      rd_ok_q <= idx_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hap_count_q <= pbwt_pkg::HAP_COUNT_RST;
      ent_valid_q <= '0;
      site_cnt_q  <= '0;
      issue_cnt_q <= '0;
      zeros_q     <= '0;
      ones_q      <= '0;
      cp_cnt_q    <= '0;
      p_q         <= '0;
      q_q         <= '0;
      s1_q        <= 1'b0;
      s2_q        <= 1'b0;
      cp_v_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        hap_count_q <= cfg_wdata_i;
      end
      if (cmd_i.restart) begin
        ent_valid_q <= '0;
        site_cnt_q  <= '0;
      end else if (pw_en) begin
        ent_valid_q[pw_addr] <= 1'b1;
      end
      if (cmd_i.out_pass) begin
        site_cnt_q <= start;
      end
      s1_q   <= issue;
      s2_q   <= s1_q;
      cp_v_q <= cp_issue;
      if (cmd_i.pass_start) begin
        issue_cnt_q <= '0;
        zeros_q     <= '0;
        ones_q      <= '0;
        cp_cnt_q    <= '0;
        p_q         <= start;
        q_q         <= start;
      end else begin
        if (issue) begin
          issue_cnt_q <= issue_cnt_q + CNT_W'(1);
        end
        if (zero_wr) begin
          zeros_q <= zeros_q + CNT_W'(1);
          p_q     <= '0;
          q_q     <= qm;
        end
        if (one_wr) begin
          ones_q <= ones_q + CNT_W'(1);
          q_q    <= '0;
          p_q    <= pm;
        end
        if (cp_issue) begin
          cp_cnt_q <= cp_cnt_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_read) begin
      result_kind_o <= pbwt_pkg::RES_READ;
      site_number_o <= OUT_W'(site_cnt_q);
      hap_id_o      <= rd_ok_q ? IDX_W'(h_eff) : '0;
      divergence_o  <= rd_ok_q ? OUT_W'(d_eff) : '0;
    end else if (cmd_i.out_pass) begin
      result_kind_o <= pbwt_pkg::RES_PASS;
      site_number_o <= OUT_W'(site_cnt_q);
      hap_id_o      <= '0;
      divergence_o  <= '0;
    end
  end

endmodule

>>> sv/pbwt_prefix_divergence_sort_unit.sv
// Top level of the prefix and divergence sort unit (positional BWT update).
// Depends on pbwt_pkg, pbwt_ctrl and pbwt_dpath.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one transaction per item:
//   an allele load, a sorted-position read, or a restart. Output channel
//   (out_valid_o / out_stall_i) returns pass-finished and read-data results.
//   cfg_we_i / cfg_wdata_i write hap_count; the user must write it only while
//   the unit is idle, which the unit itself does not enforce. A read result
//   is registered after the S_READ state. The load that carries site_last
//   starts the site pass: a scan of each sorted position in use (n) through
//   the single read port of the prefix and divergence memories, then a copy
//   of each 1-allele haplotype. A restart returns nothing.
//   One item is in work at a time; the next item is taken in the cycle the
//   pending result leaves, so a stalled receiver holds off new input.
//   Reset sets hap_count to 64, the prefix order to identity, divergences
//   and the site count to zero, and empties the output register.
module pbwt_prefix_divergence_sort_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pbwt_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  kind_i,
  input  logic [pbwt_pkg::IDX_W-1:0]  hap_index_i,
  input  logic                        allele_i,
  input  logic                        site_last_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        result_kind_o,
  output logic [pbwt_pkg::OUT_W-1:0]  site_number_o,
  output logic [pbwt_pkg::IDX_W-1:0]  hap_id_o,
  output logic [pbwt_pkg::OUT_W-1:0]  divergence_o
);

  pbwt_pkg::cmd_t cmd;
  pbwt_pkg::sts_t sts;

  pbwt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .site_last_i (site_last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  pbwt_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .hap_index_i   (hap_index_i),
    .allele_i      (allele_i),
    .result_kind_o (result_kind_o),
    .site_number_o (site_number_o),
    .hap_id_o      (hap_id_o),
    .divergence_o  (divergence_o)
  );

endmodule

>>> sv/pbwt_sva_chk.sv
// Port-level checker of the prefix and divergence sort unit, bound to the
// top level. Depends on pbwt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pbwt_sva_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        cfg_we_i,
  input logic [pbwt_pkg::CFG_W-1:0]  cfg_wdata_i,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [1:0]                  kind_i,
  input logic [pbwt_pkg::IDX_W-1:0]  hap_index_i,
  input logic                        allele_i,
  input logic                        site_last_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        result_kind_o,
  input logic [pbwt_pkg::OUT_W-1:0]  site_number_o,
  input logic [pbwt_pkg::IDX_W-1:0]  hap_id_o,
  input logic [pbwt_pkg::OUT_W-1:0]  divergence_o
);

  logic in_acc;
  logic silent_item;

  assign in_acc      = in_valid_i && !in_stall_o;
  assign silent_item = (kind_i == pbwt_pkg::KIND_RESTART) ||
                       ((kind_i == pbwt_pkg::KIND_LOAD) && !site_last_i);

  `ASSERT_AT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(result_kind_o) && $stable(site_number_o) && $stable(hap_id_o) && $stable(divergence_o)), "stalled result changed")
  `ASSERT_NEVER(a_pass_zero, clk_i, rst_ni, out_valid_o && (result_kind_o == pbwt_pkg::RES_PASS) && ((hap_id_o != '0) || (divergence_o != '0)), "pass result carries entry data")
  `ASSERT_AT(a_busy_before_result, clk_i, rst_ni, $rose(out_valid_o) |-> $past(in_stall_o), "result without work cycle")
  `ASSERT_AT(a_silent_item, clk_i, rst_ni, (in_acc && silent_item && !out_valid_o) |=> !out_valid_o, "result from a silent transaction")

endmodule

bind pbwt_prefix_divergence_sort_unit pbwt_sva_chk u_pbwt_sva_chk (.*);
